>>> hw/rtl/lad_pkg.sv
package lad_pkg;

    // Number of array slots in the storage memory.
    localparam int DEPTH = 16;

    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PW    = $clog2(DEPTH + 1);
    localparam int CAP_W = 5;
    localparam int EW    = (PW > CAP_W) ? PW : CAP_W;

    localparam int OP_W  = 3;
    localparam int VAL_W = 32;
    localparam int ST_W  = 3;

    localparam int IN_TDATA_W  = ((OP_W + VAL_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((ST_W + VAL_W + 7) / 8) * 8;

    typedef enum logic [OP_W-1:0] {
        OP_INS_FRONT = 3'd0,
        OP_INS_REAR  = 3'd1,
        OP_DEL_FRONT = 3'd2,
        OP_DEL_REAR  = 3'd3,
        OP_LIST      = 3'd4
    } lad_op_t;

    typedef enum logic [ST_W-1:0] {
        ST_DONE   = 3'd0,
        ST_FULL   = 3'd1,
        ST_NOROOM = 3'd2,
        ST_EMPTY  = 3'd3,
        ST_ELEM   = 3'd4
    } lad_status_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EMIT = 2'b10
    } lad_state_t;

    typedef struct packed {
        logic             we;
        logic [AW-1:0]    waddr;
        logic [VAL_W-1:0] wdata;
        logic             re;
        logic [AW-1:0]    raddr;
    } lad_mem_req_t;

endpackage

>>> hw/rtl/lad_ram.sv
module lad_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        // Read data holds until the next read is issued.
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/lad_ctrl.sv
module lad_ctrl
    import lad_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CAP_W-1:0]       cfg_data,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,
    output logic                   m_tlast,
    output lad_mem_req_t           mem_req,
    input  logic [VAL_W-1:0]       mem_rdata
);

    lad_state_t         state_reg, state_next;
    logic [CAP_W-1:0]   cap_reg, cap_next;
    logic [PW-1:0]      front_reg, front_next;
    logic [PW-1:0]      rear_reg, rear_next;
    logic [PW-1:0]      idx_reg, idx_next;
    logic               out_valid_reg, out_valid_next;
    lad_status_t        out_status_reg, out_status_next;
    logic [VAL_W-1:0]   out_value_reg, out_value_next;
    logic               out_last_reg, out_last_next;

    logic               out_free;
    logic               in_fire;
    lad_op_t            op;
    logic [VAL_W-1:0]   in_value;
    logic [EW-1:0]      cap_ext;
    logic [PW-1:0]      cap_eff;
    logic               is_empty;
    logic               is_full;
    logic [PW-1:0]      front_dec;
    logic [PW-1:0]      idx_inc;

    assign out_free  = !out_valid_reg || m_tready;
    assign cfg_ready = (state_reg == S_IDLE);
    assign s_tready  = (state_reg == S_IDLE) && out_free && !cfg_valid;
    assign in_fire   = s_tvalid && s_tready;

    assign op       = lad_op_t'(s_tdata[OP_W-1:0]);
    assign in_value = s_tdata[OP_W +: VAL_W];

    // A capacity of zero acts as one slot, and one above the array size is clamped.
    assign cap_ext = EW'(cap_reg);
    always_comb begin
        if (cap_reg == '0) begin
            cap_eff = PW'(1);
        end else if (cap_ext > EW'(DEPTH)) begin
            cap_eff = PW'(DEPTH);
        end else begin
            cap_eff = PW'(cap_ext);
        end
    end

    assign is_empty  = (rear_reg == '0) || (front_reg >= rear_reg);
    assign is_full   = (front_reg == '0) && (rear_reg == cap_eff);
    assign front_dec = front_reg - PW'(1);
    assign idx_inc   = idx_reg + PW'(1);

    // Only one access is made per cycle and a write lands before any later
    // read is issued, so the memory needs no forwarding path.
    always_comb begin
        state_next      = state_reg;
        cap_next        = cap_reg;
        front_next      = front_reg;
        rear_next       = rear_reg;
        idx_next        = idx_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_value_next  = out_value_reg;
        out_last_next   = out_last_reg;
        mem_req         = '0;

        case (state_reg)
            S_IDLE: begin
                if (in_fire) begin
                    out_value_next = '0;
                    out_last_next  = 1'b1;
                    case (op)
                        OP_INS_FRONT: begin
                            out_valid_next = 1'b1;
                            if (is_full) begin
                                out_status_next = ST_FULL;
                            end else if (front_reg == '0) begin
                                out_status_next = ST_NOROOM;
                            end else begin
                                out_status_next = ST_DONE;
                                front_next      = front_dec;
                                mem_req.we      = 1'b1;
                                mem_req.waddr   = front_dec[AW-1:0];
                                mem_req.wdata   = in_value;
                            end
                        end
                        OP_INS_REAR: begin
                            out_valid_next = 1'b1;
                            if (is_full) begin
                                out_status_next = ST_FULL;
                            end else if (rear_reg >= cap_eff) begin
                                out_status_next = ST_NOROOM;
                            end else begin
                                out_status_next = ST_DONE;
                                rear_next       = rear_reg + PW'(1);
                                mem_req.we      = 1'b1;
                                mem_req.waddr   = rear_reg[AW-1:0];
                                mem_req.wdata   = in_value;
                            end
                        end
                        OP_DEL_FRONT: begin
                            out_valid_next = 1'b1;
                            if (is_empty) begin
                                out_status_next = ST_EMPTY;
                            end else begin
                                out_status_next = ST_DONE;
                                front_next      = front_reg + PW'(1);
                            end
                        end
                        OP_DEL_REAR: begin
                            out_valid_next = 1'b1;
                            if (is_empty) begin
                                out_status_next = ST_EMPTY;
                            end else begin
                                out_status_next = ST_DONE;
                                rear_next       = rear_reg - PW'(1);
                            end
                        end
                        OP_LIST: begin
                            if (is_empty) begin
                                out_valid_next  = 1'b1;
                                out_status_next = ST_EMPTY;
                            end else begin
                                mem_req.re    = 1'b1;
                                mem_req.raddr = front_reg[AW-1:0];
                                idx_next      = front_reg;
                                state_next    = S_EMIT;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_EMIT: begin
                // The element last read goes out while the next read is issued.
                if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_status_next = ST_ELEM;
                    out_value_next  = mem_rdata;
                    out_last_next   = (idx_inc == rear_reg);
                    if (idx_inc == rear_reg) begin
                        state_next = S_IDLE;
                    end else begin
                        idx_next      = idx_inc;
                        mem_req.re    = 1'b1;
                        mem_req.raddr = idx_inc[AW-1:0];
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // Writing the capacity creates the queue anew.
        if (cfg_valid && cfg_ready) begin
            cap_next   = cfg_data;
            front_next = '0;
            rear_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            cap_reg       <= CAP_W'(16);
            front_reg     <= '0;
            rear_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cap_reg       <= cap_next;
            front_reg     <= front_next;
            rear_reg      <= rear_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg        <= idx_next;
        out_status_reg <= out_status_next;
        out_value_reg  <= out_value_next;
        out_last_reg   <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_TDATA_W'({out_value_reg, out_status_reg});
    assign m_tlast  = out_last_reg;

endmodule

>>> hw/rtl/linear_array_deque.sv
// Double-ended queue kept in a linear array of slots held in one synchronous
// RAM. Each input beat inserts at the front or rear, deletes at the front or
// rear, or lists the contents; op codes 5 to 7 are consumed without a result.
// Inserts and deletes return one result beat each. A list first issues the
// RAM read of the front element, then returns one element per cycle through
// the single read port while the result side does not stall; the final
// element carries tlast. A list of an empty queue returns one "empty" beat.
// Writing the capacity empties the queue; write it only while no beat is in
// flight. A result register sits on the output, so a new beat is taken only
// when no result waits or in the cycle that the waiting result leaves.
module linear_array_deque
    import lad_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CAP_W-1:0]       cfg_data,      // capacity
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,       // op[2:0], value[34:3], zero pad
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,       // status[2:0], value_res[34:3], zero pad
    output logic                   m_tlast
);

    lad_mem_req_t     mem_req;
    logic [VAL_W-1:0] mem_rdata;

    lad_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .mem_req   (mem_req),
        .mem_rdata (mem_rdata)
    );

    lad_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_slots (
        .clk   (aclk),
        .we    (mem_req.we),
        .waddr (mem_req.waddr),
        .wdata (mem_req.wdata),
        .re    (mem_req.re),
        .raddr (mem_req.raddr),
        .rdata (mem_rdata)
    );

endmodule

>>> hw/rtl/lad_checker.sv
module lad_checker
    import lad_pkg::*;
(
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   cfg_valid,
    input logic                   cfg_ready,
    input logic [CAP_W-1:0]       cfg_data,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic [IN_TDATA_W-1:0]  s_tdata,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata,
    input logic                   m_tlast
);

    // A stalled result beat keeps its contents.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result beat changed while stalled");

    // Every status other than a listed element is the only beat of its item.
    a_single_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[ST_W-1:0] != ST_ELEM) |-> m_tlast)
        else $error("non-element result without tlast");

    // Only listed elements carry a value.
    a_value_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[ST_W-1:0] != ST_ELEM) |-> (m_tdata[ST_W +: VAL_W] == '0))
        else $error("non-element result with a nonzero value");

    // The result channel is empty right after reset.
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind linear_array_deque lad_checker u_lad_checker (.*);
